>>> src/fvc_pkg.sv
// ----------------------------------------------------------------------------
// fvc_pkg: shared types and constants of the flywheel velocity controller
// Q.8 thresholds, gain codes, saturation bounds and register indexes.
// ----------------------------------------------------------------------------
package fvc_pkg;

    localparam int TICKS_PER_REV_DEF = 392;
    localparam int ADAPT_HOLD_MS_DEF = 1000;

    localparam logic signed [23:0] S24_MAX = 24'sh7fffff;
    localparam logic signed [23:0] S24_MIN = -24'sh800000;
    localparam logic signed [23:0] E_HI    = 24'sd5120;
    localparam logic signed [23:0] E_LO    = 24'sd1280;
    localparam logic [8:0]         GAIN_HIGH = 9'd384;
    localparam logic [8:0]         GAIN_LOW  = 9'd179;
    localparam logic signed [11:0] TRIM_MAX = 12'sd1270;

    localparam logic [2:0] REG_RANGE  = 3'd0;
    localparam logic [2:0] REG_TARGET = 3'd1;
    localparam logic [2:0] REG_POWER  = 3'd2;
    localparam logic [2:0] REG_PI     = 3'd3;
    localparam logic [2:0] REG_IGAIN  = 3'd4;

    // Start request and quotient sign from the sequencer to the divider.
    typedef struct packed {
        logic        start;
        logic        neg;
    } div_ctl_t;

endpackage

>>> src/fvc_div.sv
// ----------------------------------------------------------------------------
// fvc_div: bit-serial restoring divider
// Divides a 64-bit magnitude by a 48-bit magnitude, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fvc_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fvc_pkg::div_ctl_t    ctl,
    input  logic [63:0]          dividend,
    input  logic [47:0]          divisor,
    output logic                 done,
    output logic signed [64:0]   quotient
);
    import fvc_pkg::*;

    logic [63:0] q_reg, q_next;
    logic [48:0] rem_reg, rem_next;
    logic [47:0] dvs_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [49:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[63]} - {2'b00, dvs_reg};
        if (busy_reg)
        begin
            if (!trial[49])
            begin
                rem_next = trial[48:0];
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[47:0], q_reg[63]};
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd64;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= ctl.neg;
        end
        else
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

>>> src/flywheel_velocity_controller_top.sv
// ----------------------------------------------------------------------------
// flywheel_velocity_controller_top: bang-bang flywheel speed control with PI
// Measures speed from encoder beats and sets the motor drive and trims.
// ----------------------------------------------------------------------------
// Each input beat carries an encoder count and two millisecond timestamps and
// yields exactly one output beat. The speed quotient comes from a bit-serial
// divider that retires one quotient bit per cycle; the sequencer then steps
// through the error terms (ST_ERR), the P and I products (ST_PI), the drive
// selection and trim adaptation (ST_DRV) and the load of the output register
// (ST_OUT). The next input beat is accepted only once the sequencer is back
// in ST_IDLE. When the encoder timestamp has not moved, the division is
// skipped and the speed saturates, or is zero if the count has not changed.
// One beat is computed at a time; s_tready is high whenever the sequencer is
// idle. A finished result waits in the output register without holding off
// the input; only when a second result is done while the first is still
// unaccepted does the sequencer wait, and s_tready stays low until the
// receiver takes the first one. Configuration writes take effect at once and
// are meant for periods with no beat in flight.
module flywheel_velocity_controller_top
#(
    parameter int TICKS_PER_REV = fvc_pkg::TICKS_PER_REV_DEF,
    parameter int ADAPT_HOLD_MS = fvc_pkg::ADAPT_HOLD_MS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [8:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // encoder_count[31:0], encoder_time_ms[63:32], system_time_ms[95:64]
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // drive[7:0], at_full_speed[8], measured_rpm[24:9],
    // current_trim_tenths[36:25], zero fill [39:37]
    output logic [39:0]  m_tdata
);
    import fvc_pkg::*;

    localparam logic [31:0] HOLD = 32'(ADAPT_HOLD_MS);
    localparam logic [47:0] TPR  = 48'(TICKS_PER_REV);

    typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_ERR, ST_PI, ST_DRV, ST_OUT} st_t;

    logic [2:0]         range_reg;
    logic [8:0]         target_reg;
    logic signed [7:0]  power_reg;
    logic               pi_reg;
    logic [7:0]         igain_reg;

    logic [31:0]        last_enc_reg, last_time_reg, start_reg, now_reg;
    logic signed [23:0] verr_reg, integ_reg, rpm_reg, cur_reg, avg_reg, last_reg;
    logic [8:0]         pgain_reg;
    logic               full_reg;
    logic signed [11:0] trims_reg [4];
    logic signed [7:0]  held_reg;
    logic signed [24:0] pterm_reg;
    st_t                st_reg;
    logic               mv_reg;
    logic [39:0]        mdata_reg;

    div_ctl_t           dctl;
    logic               ddone;
    logic signed [64:0] dq;

    logic [31:0]        d_ms;
    logic [63:0]        dnd;
    logic [47:0]        dvs;
    logic [1:0]         ti;
    logic signed [24:0] cur_w;
    logic signed [25:0] filt;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v > 48'(S24_MAX))      return S24_MAX;
        else if (v < 48'(S24_MIN)) return S24_MIN;
        else                       return v[23:0];
    endfunction

    function automatic logic signed [7:0] sat8(input logic signed [31:0] v);
        if (v > 32'sd127)       return 8'sd127;
        else if (v < -32'sd127) return -8'sd127;
        else                    return v[7:0];
    endfunction

    // Division by ten, truncating toward zero, for magnitudes up to 2550.
    function automatic logic signed [12:0] div10(input logic signed [12:0] v);
        logic [12:0] mag;
        logic [25:0] prod;
        logic [12:0] q;
        mag  = v[12] ? 13'(-v) : 13'(v);
        prod = 26'(mag) * 26'd6554;
        q    = 13'(prod[25:16]);
        return v[12] ? -$signed(q) : $signed(q);
    endfunction

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

    assign d_ms = s_tdata[63:32] - last_time_reg;
    assign ti   = (range_reg >= 3'd4) ? 2'd3 : 2'(range_reg - 3'd1);

    // Magnitude of 60000*256 times the count change, over TICKS_PER_REV times
    // the elapsed milliseconds.
    always_comb
    begin
        logic [31:0]        dc;
        logic signed [32:0] de;
        logic [32:0]        mag;
        dc   = s_tdata[31:0] - last_enc_reg;
        de   = $signed({dc[31], dc});
        mag  = de[32] ? 33'(-de) : 33'(de);
        dnd  = 64'(mag) * 64'd15360000;
        dvs  = TPR * 48'(d_ms);
        dctl.start = s_tvalid && s_tready && (d_ms != 32'd0);
        dctl.neg   = de[32];
    end

    assign cur_w = 25'(target_reg) * 25'sd256 - 25'(rpm_reg);
    assign filt  = (26'(cur_reg) + 26'sd3 * 26'(last_reg)) / 4;

    fvc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dctl),
        .dividend (dnd),
        .divisor  (dvs),
        .done     (ddone),
        .quotient (dq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= '0; target_reg <= '0; power_reg <= '0; pi_reg <= 1'b0;
            igain_reg <= 8'd179;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE:  range_reg  <= cfg_data[2:0];
                REG_TARGET: target_reg <= cfg_data;
                REG_POWER:  power_reg  <= cfg_data[7:0];
                REG_PI:     pi_reg     <= cfg_data[0];
                REG_IGAIN:  igain_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; mv_reg <= 1'b0; mdata_reg <= '0;
            last_enc_reg <= '0; last_time_reg <= '0; verr_reg <= '0;
            integ_reg <= '0; pgain_reg <= GAIN_HIGH; full_reg <= 1'b0;
            start_reg <= '0; held_reg <= '0;
            for (int i = 0; i < 4; i++) trims_reg[i] <= '0;
            rpm_reg <= '0; cur_reg <= '0; avg_reg <= '0; last_reg <= '0;
            pterm_reg <= '0; now_reg <= '0;
        end
        else
        begin
            if (mv_reg && m_tready && st_reg != ST_OUT) mv_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                    if (s_tvalid && s_tready)
                    begin
                        last_enc_reg  <= s_tdata[31:0];
                        last_time_reg <= s_tdata[63:32];
                        now_reg       <= s_tdata[95:64];
                        if (d_ms == 32'd0)
                        begin
                            if (s_tdata[31:0] == last_enc_reg) rpm_reg <= '0;
                            else if ((s_tdata[31:0] - last_enc_reg) >= 32'h80000000)
                                rpm_reg <= S24_MIN;
                            else rpm_reg <= S24_MAX;
                            st_reg <= ST_ERR;
                        end
                        else st_reg <= ST_DIV;
                    end
                ST_DIV:
                    if (ddone)
                    begin
                        if (dq > 65'(S24_MAX))      rpm_reg <= S24_MAX;
                        else if (dq < 65'(S24_MIN)) rpm_reg <= S24_MIN;
                        else                        rpm_reg <= dq[23:0];
                        st_reg <= ST_ERR;
                    end
                ST_ERR:
                begin
                    logic signed [23:0] c;
                    c = sat24(48'(cur_w));
                    cur_reg  <= c;
                    last_reg <= verr_reg;
                    verr_reg <= c;
                    avg_reg  <= 24'((25'(verr_reg) + 25'(c)) / 2);
                    st_reg   <= ST_PI;
                end
                ST_PI:
                begin
                    logic signed [47:0] it;
                    pterm_reg <= 25'((48'(avg_reg) * $signed({1'b0, pgain_reg})) / 256);
                    it = ((48'(integ_reg) + 48'(avg_reg)) * $signed({1'b0, igain_reg})) / 256;
                    integ_reg <= (cur_reg > E_HI) ? '0 : sat24(it);
                    if (cur_reg > E_HI) pgain_reg <= GAIN_HIGH;
                    if (cur_reg < E_LO) pgain_reg <= GAIN_LOW;
                    st_reg <= ST_DRV;
                end
                ST_DRV:
                begin
                    logic signed [7:0]  h;
                    logic               f;
                    logic [31:0]        s;
                    logic signed [12:0] t;
                    h = held_reg; f = full_reg; s = start_reg;
                    if (range_reg == 3'd0) h = '0;
                    else if (range_reg >= 3'd4 && pi_reg)
                    begin
                        f = 1'b0;
                        h = sat8(32'((34'(pterm_reg) + 34'(integ_reg)
                                 + 34'(power_reg) * 34'sd256) / 256));
                    end
                    else
                    begin
                        if (full_reg) s = now_reg;
                        if (avg_reg < E_LO)
                        begin
                            f = 1'b0;
                            h = sat8(32'(div10(13'(power_reg) * 13'sd10
                                     + 13'(trims_reg[ti]))));
                        end
                    end
                    if (avg_reg > E_HI)
                    begin
                        h = 8'sd127; f = 1'b1;
                    end
                    t = 13'(trims_reg[ti]);
                    if (!f && range_reg != 3'd0 && (now_reg - s) > HOLD)
                    begin
                        if (filt > 26'(E_LO))       t = t + ((ti == 2'd3) ? 13'sd2 : 13'sd1);
                        else if (filt < -26'(E_LO)) t = t - ((ti == 2'd3) ? 13'sd2 : 13'sd1);
                        if (t > 13'(TRIM_MAX)) t = 13'(TRIM_MAX);
                        if (t < -13'(TRIM_MAX)) t = -13'(TRIM_MAX);
                        trims_reg[ti] <= t[11:0];
                    end
                    held_reg <= h; full_reg <= f; start_reg <= s;
                    st_reg <= ST_OUT;
                end
                ST_OUT:
                    // The result is taken from the state registers once the
                    // output register is free or being drained.
                    if (!mv_reg || m_tready)
                    begin
                        mdata_reg <= {3'b000, (range_reg != 3'd0) ? trims_reg[ti] : 12'sd0,
                                      (rpm_reg / 256) > 24'sd32767 ? 16'sh7fff :
                                      ((rpm_reg / 256) < -24'sd32768 ? 16'sh8000
                                       : 16'(rpm_reg / 256)), full_reg, held_reg};
                        mv_reg <= 1'b1;
                        st_reg <= ST_IDLE;
                    end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
